FILE: rtl/elerp_pkg.sv
// ---------------------------------------------------------------------------
// elerp_pkg: shared types and codes of the eased interpolation unit
// Type codes, easing codes, lane handling kinds and the lane control bundle.
// ---------------------------------------------------------------------------
package elerp_pkg;

	localparam int DATA_W = 32;
	localparam int TYPE_W = 3;
	localparam int OP_W   = 3;
	localparam int LANES  = 4;

	localparam logic [TYPE_W-1:0] TYPE_SCALAR  = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_VEC2    = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_VEC3    = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_VEC4    = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_BOOL    = 3'd4;
	localparam logic [TYPE_W-1:0] TYPE_INT     = 3'd5;
	localparam logic [TYPE_W-1:0] TYPE_OTHER   = 3'd6;
	localparam logic [TYPE_W-1:0] TYPE_INVALID = 3'd7;

	localparam logic [OP_W-1:0] OP_LINEAR      = 3'd0;
	localparam logic [OP_W-1:0] OP_EASE        = 3'd1;
	localparam logic [OP_W-1:0] OP_IN_QUAD     = 3'd2;
	localparam logic [OP_W-1:0] OP_OUT_QUAD    = 3'd3;
	localparam logic [OP_W-1:0] OP_IN_OUT_QUAD = 3'd4;

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_BOOL,
		KIND_INT,
		KIND_FIXED
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  used;
	} lane_ctl_t;

endpackage

FILE: rtl/elerp_ease.sv
// ---------------------------------------------------------------------------
// elerp_ease: position clamp and quadratic easing
// Three register stages: clamp and operand select, square, shift and fold.
// ---------------------------------------------------------------------------
module elerp_ease import elerp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic [OP_W-1:0]          operation,
	input  logic signed [DATA_W-1:0] position,
	output logic [FRAC_BITS:0]       eased
);

	localparam int T_W = FRAC_BITS + 1;
	localparam int SQ_W = 2 * T_W;
	localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;
	localparam logic [T_W-1:0] HALF = T_W'(1) << (FRAC_BITS - 1);
	localparam logic [T_W:0] TWO_ONE = (T_W + 1)'(1) << (FRAC_BITS + 1);
	localparam logic signed [DATA_W-1:0] ONE_W = DATA_W'(1) << FRAC_BITS;

	typedef enum logic [2:0] {
		SQ_LINEAR,
		SQ_IN,
		SQ_OUT,
		SQ_INOUT_LO,
		SQ_INOUT_HI
	} sq_sel_t;

	logic [T_W-1:0]  t_c;
	logic [T_W-1:0]  s_c;
	logic [T_W:0]    s_hi;
	sq_sel_t         sel_c;
	logic [T_W-1:0]  t_s1, s_s1, t_s2;
	sq_sel_t         sel_s1, sel_s2;
	logic [SQ_W-1:0] sq_s2;
	logic [T_W-1:0]  e_c;
	logic [T_W-1:0]  e_s3;

	always_comb begin
		if (position[DATA_W-1]) begin
			t_c = '0;
		end else if (position > ONE_W) begin
			t_c = ONE;
		end else begin
			t_c = position[T_W-1:0];
		end
		s_hi = TWO_ONE - {t_c, 1'b0};
		unique case (operation)
			OP_IN_QUAD: begin
				sel_c = SQ_IN;
				s_c = t_c;
			end
			OP_OUT_QUAD: begin
				sel_c = SQ_OUT;
				s_c = ONE - t_c;
			end
			OP_EASE, OP_IN_OUT_QUAD: begin
				if (t_c < HALF) begin
					sel_c = SQ_INOUT_LO;
					s_c = t_c;
				end else begin
					sel_c = SQ_INOUT_HI;
					s_c = s_hi[T_W-1:0];
				end
			end
			default: begin
				sel_c = SQ_LINEAR;
				s_c = t_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		t_s1 <= t_c;
		s_s1 <= s_c;
		sel_s1 <= sel_c;
		t_s2 <= t_s1;
		sel_s2 <= sel_s1;
		sq_s2 <= s_s1 * s_s1;
		e_s3 <= e_c;
	end

	always_comb begin
		unique case (sel_s2)
			SQ_IN:       e_c = sq_s2[FRAC_BITS +: T_W];
			SQ_OUT:      e_c = ONE - sq_s2[FRAC_BITS +: T_W];
			SQ_INOUT_LO: e_c = sq_s2[FRAC_BITS - 1 +: T_W];
			SQ_INOUT_HI: e_c = ONE - sq_s2[FRAC_BITS + 1 +: T_W];
			default:     e_c = t_s2;
		endcase
	end

	assign eased = e_s3;

endmodule

FILE: rtl/elerp_lane.sv
// ---------------------------------------------------------------------------
// elerp_lane: one result lane
// Multiply the lane difference by the eased position, then add, round and
// select by kind. Two register stages.
// ---------------------------------------------------------------------------
module elerp_lane import elerp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic [FRAC_BITS:0]       eased,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W:0]   d,
	input  lane_ctl_t                ctl,
	output logic signed [DATA_W-1:0] result
);

	localparam int T_W = FRAC_BITS + 1;
	localparam int P_W = DATA_W + 1 + T_W + 1;
	localparam logic [T_W-1:0] HALF = T_W'(1) << (FRAC_BITS - 1);

	logic signed [P_W-1:0]    prod_s4;
	logic signed [DATA_W-1:0] a_s4, b_s4;
	lane_ctl_t                ctl_s4;
	logic                     pick_b_s4;
	logic [DATA_W-1:0]        w_c;
	logic [DATA_W-1:0]        r_c;
	logic signed [DATA_W-1:0] result_s5;

	always_ff @(posedge clk) begin
		prod_s4 <= d * $signed({1'b0, eased});
		a_s4 <= a;
		b_s4 <= a + d[DATA_W-1:0];
		ctl_s4 <= ctl;
		pick_b_s4 <= (eased >= HALF);
		result_s5 <= r_c;
	end

	always_comb begin
		w_c = a_s4 + prod_s4[FRAC_BITS +: DATA_W];
		unique case (ctl_s4.kind)
			KIND_PASS:  r_c = a_s4;
			KIND_BOOL:  r_c = pick_b_s4 ? b_s4 : a_s4;
			KIND_INT:   r_c = w_c + DATA_W'(w_c[DATA_W-1] && (prod_s4[FRAC_BITS-1:0] != '0));
			KIND_FIXED: r_c = w_c;
			default:    r_c = a_s4;
		endcase
		if (!ctl_s4.used) begin
			r_c = '0;
		end
	end

	assign result = result_s5;

endmodule

FILE: rtl/eased_lerp_unit.sv
// ---------------------------------------------------------------------------
// eased_lerp_unit: interpolation of up to four lanes with quadratic easing
// An accepted start is carried through valid_s1 to valid_s5, and valid_s5 drives done.
// Throughput: one item every cycle; busy stays low, five-stage pipeline
// (clamp, square, ease, lane multiply, add and round).
// Reset clears the stage valid bits only; done is low out of reset.
// The receiver cannot stall: done marks a result for exactly one cycle.
// ---------------------------------------------------------------------------
module eased_lerp_unit import elerp_pkg::*; #(
	parameter int FRAC_BITS  = 16,
	parameter int LANE_COUNT = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          operation,
	input  logic [TYPE_W-1:0]        first_type,
	input  logic [TYPE_W-1:0]        second_type,
	input  logic signed [DATA_W-1:0] position,
	input  logic signed [DATA_W-1:0] first_lane0,
	input  logic signed [DATA_W-1:0] first_lane1,
	input  logic signed [DATA_W-1:0] first_lane2,
	input  logic signed [DATA_W-1:0] first_lane3,
	input  logic signed [DATA_W-1:0] second_lane0,
	input  logic signed [DATA_W-1:0] second_lane1,
	input  logic signed [DATA_W-1:0] second_lane2,
	input  logic signed [DATA_W-1:0] second_lane3,
	output logic                     done,
	output logic [TYPE_W-1:0]        result_type,
	output logic signed [DATA_W-1:0] result_lane0,
	output logic signed [DATA_W-1:0] result_lane1,
	output logic signed [DATA_W-1:0] result_lane2,
	output logic signed [DATA_W-1:0] result_lane3
);

	logic signed [DATA_W-1:0] a_in [LANES];
	logic signed [DATA_W-1:0] b_in [LANES];
	logic signed [DATA_W-1:0] res [LANES];
	kind_t                    kind_c;
	logic [LANES-1:0]         used_c;

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [TYPE_W-1:0]        type_s1, type_s2, type_s3, type_s4, type_s5;
	kind_t                    kind_s1, kind_s2, kind_s3;
	logic [LANES-1:0]         used_s1, used_s2, used_s3;
	logic signed [DATA_W-1:0] a_s1 [LANES];
	logic signed [DATA_W-1:0] a_s2 [LANES];
	logic signed [DATA_W-1:0] a_s3 [LANES];
	logic signed [DATA_W:0]   d_s1 [LANES];
	logic signed [DATA_W:0]   d_s2 [LANES];
	logic signed [DATA_W:0]   d_s3 [LANES];
	logic [FRAC_BITS:0]       eased;

	assign busy = 1'b0;

	assign a_in[0] = first_lane0;
	assign a_in[1] = first_lane1;
	assign a_in[2] = first_lane2;
	assign a_in[3] = first_lane3;
	assign b_in[0] = second_lane0;
	assign b_in[1] = second_lane1;
	assign b_in[2] = second_lane2;
	assign b_in[3] = second_lane3;

	always_comb begin
		if (first_type == TYPE_INVALID || second_type == TYPE_INVALID ||
				first_type != second_type || first_type == TYPE_OTHER) begin
			kind_c = KIND_PASS;
		end else if (first_type == TYPE_BOOL) begin
			kind_c = KIND_BOOL;
		end else if (first_type == TYPE_INT) begin
			kind_c = KIND_INT;
		end else begin
			kind_c = KIND_FIXED;
		end
		unique case (first_type)
			TYPE_SCALAR, TYPE_BOOL, TYPE_INT: used_c = 4'b0001;
			TYPE_VEC2:                        used_c = 4'b0011;
			TYPE_VEC3:                        used_c = 4'b0111;
			default:                          used_c = 4'b1111;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		type_s1 <= first_type;
		type_s2 <= type_s1;
		type_s3 <= type_s2;
		type_s4 <= type_s3;
		type_s5 <= type_s4;
		kind_s1 <= kind_c;
		kind_s2 <= kind_s1;
		kind_s3 <= kind_s2;
		used_s1 <= used_c;
		used_s2 <= used_s1;
		used_s3 <= used_s2;
		for (int i = 0; i < LANES; i++) begin
			a_s1[i] <= a_in[i];
			a_s2[i] <= a_s1[i];
			a_s3[i] <= a_s2[i];
			d_s1[i] <= {b_in[i][DATA_W-1], b_in[i]} - {a_in[i][DATA_W-1], a_in[i]};
			d_s2[i] <= d_s1[i];
			d_s3[i] <= d_s2[i];
		end
	end

	elerp_ease #(
		.FRAC_BITS(FRAC_BITS)
	) u_ease (
		.clk(clk),
		.operation(operation),
		.position(position),
		.eased(eased)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		if (g < LANE_COUNT) begin : g_on
			lane_ctl_t ctl;
			assign ctl = {kind_s3, used_s3[g]};
			elerp_lane #(
				.FRAC_BITS(FRAC_BITS)
			) u_lane (
				.clk(clk),
				.eased(eased),
				.a(a_s3[g]),
				.d(d_s3[g]),
				.ctl(ctl),
				.result(res[g])
			);
		end else begin : g_off
			assign res[g] = '0;
		end
	end

	assign done = valid_s5;
	assign result_type = type_s5;
	assign result_lane0 = res[0];
	assign result_lane1 = res[1];
	assign result_lane2 = res[2];
	assign result_lane3 = res[3];

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##5 done)
		else $error("accepted item did not complete after five cycles");

	a_type_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result_type == $past(first_type, 5))
		else $error("result type does not match the first type of its item");

	a_invalid_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_type == TYPE_INVALID |-> result_lane0 == $past(first_lane0, 5))
		else $error("invalid type did not pass the first value through");

	a_scalar_unused: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_type == TYPE_SCALAR |-> result_lane1 == '0 && result_lane3 == '0)
		else $error("unused lane of a scalar result is not zero");

endmodule
